/* hdl/plist_pkg.sv */
`default_nettype none

package plist_pkg;

    localparam int MODE_W = 2;
    localparam int POS_W  = 8;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GET    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LOCATE = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

`default_nettype wire

/* hdl/plist_ctrl.sv */
`default_nettype none

module plist_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   o_done,
    output plist_pkg::t_dp_cmd     o_cmd
);
    import plist_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                n_state = start ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy       = 1'b0;
        o_done     = 1'b0;
        o_cmd.exec = 1'b0;
        unique case (r_state)
            S_IDLE: begin
            end
            S_EXEC: begin
                busy       = 1'b1;
                o_cmd.exec = 1'b1;
            end
            S_FIN: begin
                o_done = 1'b1;
            end
            default: begin
            end
        endcase
        o_cmd.load = start && !busy;
    end

endmodule

`default_nettype wire

/* hdl/plist_dp.sv */
`default_nettype none

module plist_dp #(
    parameter int CAPACITY = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire plist_pkg::t_dp_cmd                     i_cmd,
    input  wire logic [plist_pkg::MODE_W-1:0]           i_mode,
    input  wire logic [plist_pkg::POS_W-1:0]            i_position,
    input  wire logic signed [plist_pkg::VAL_W-1:0]     i_value,
    output logic [plist_pkg::STAT_W-1:0]                o_status,
    output logic signed [plist_pkg::VAL_W-1:0]          o_read_value,
    output logic [plist_pkg::POS_W-1:0]                 o_found_position,
    output logic [plist_pkg::POS_W-1:0]                 o_length
);
    import plist_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [MODE_W-1:0]        r_mode;
    logic [POS_W-1:0]         r_pos;
    logic [VAL_W-1:0]         r_val;
    logic [VAL_W-1:0]         r_cells [CAPACITY];
    logic [VAL_W-1:0]         n_cells [CAPACITY];
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic [CAPACITY-1:0]      r_match;
    logic [CAPACITY-1:0]      n_match;
    logic [STAT_W-1:0]        r_status;
    logic [STAT_W-1:0]        n_status;
    logic [VAL_W-1:0]         r_read;
    logic [VAL_W-1:0]         n_read;
    logic                     r_is_loc;

    logic [POS_W:0]           pos_ext;
    logic [POS_W:0]           cnt_ext;
    logic [POS_W:0]           pos_m1;
    logic [IW-1:0]            rd_idx;
    logic                     pos_zero;
    logic                     full;
    logic                     ins_ok;
    logic                     del_ok;
    logic [POS_W-1:0]         found;

    assign pos_ext  = (POS_W + 1)'(r_pos);
    assign cnt_ext  = (POS_W + 1)'(r_count);
    assign pos_m1   = pos_ext - (POS_W + 1)'(1);
    assign rd_idx   = pos_m1[IW-1:0];
    assign pos_zero = (r_pos == '0);
    assign full     = (r_count == CW'(CAPACITY));

    always_comb begin
        ins_ok   = 1'b0;
        del_ok   = 1'b0;
        n_status = ST_OK;
        n_read   = '0;
        n_count  = r_count;
        unique case (r_mode)
            MODE_INSERT: begin
                if (pos_zero || pos_ext > cnt_ext + (POS_W + 1)'(1)) begin
                    n_status = ST_RANGE;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ins_ok  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            MODE_DELETE: begin
                if (pos_zero || pos_ext > cnt_ext) begin
                    n_status = ST_RANGE;
                end else begin
                    del_ok  = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            MODE_GET: begin
                if (pos_zero || pos_ext > cnt_ext) begin
                    n_status = ST_RANGE;
                end else begin
                    n_read = r_cells[rd_idx];
                end
            end
            MODE_LOCATE: begin
                n_status = ST_NOTFOUND;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic at_or_after;
        assign at_or_after = ((POS_W + 1)'(k) >= pos_m1);
        assign n_match[k]  = (CW'(k) < r_count) && (r_cells[k] == r_val);

        if (k == 0) begin : g_first
            always_comb begin
                n_cells[k] = r_cells[k];
                if (ins_ok && at_or_after) begin
                    n_cells[k] = r_val;
                end else if (del_ok && at_or_after && k < CAPACITY - 1) begin
                    n_cells[k] = r_cells[(k + 1) % CAPACITY];
                end
            end
        end else begin : g_rest
            always_comb begin
                n_cells[k] = r_cells[k];
                if (ins_ok && at_or_after) begin
                    n_cells[k] = ((POS_W + 1)'(k) == pos_m1) ? r_val : r_cells[k - 1];
                end else if (del_ok && at_or_after && k < CAPACITY - 1) begin
                    n_cells[k] = r_cells[(k + 1) % CAPACITY];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_pos  <= i_position;
            r_val  <= i_value;
        end
        if (i_cmd.exec) begin
            r_cells  <= n_cells;
            r_match  <= n_match;
            r_status <= n_status;
            r_read   <= n_read;
            r_is_loc <= (r_mode == MODE_LOCATE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    // lowest matching slot wins
    always_comb begin
        found = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (r_match[k]) found = POS_W'(k + 1);
        end
    end

    always_comb begin
        o_status         = r_status;
        o_found_position = '0;
        if (r_is_loc) begin
            o_status         = (|r_match) ? ST_OK : ST_NOTFOUND;
            o_found_position = found;
        end
    end

    assign o_read_value = r_read;
    assign o_length     = POS_W'(r_count);

endmodule

`default_nettype wire

/* hdl/positional_list_engine.sv */
// positional_list_engine: ordered list of up to CAPACITY signed 32-bit values
// request channel: drive i_mode, i_position, i_value with start; the request
//   is taken at a rising edge where start is high and busy is low
// modes: insert at 1-based position, delete at position, get at position,
//   locate the first position holding i_value
// result channel: o_done is high for one cycle; o_status, o_read_value,
//   o_found_position and o_length are valid in that cycle only
// sequence: the request edge enters S_EXEC, and o_done is high in S_FIN, after it;
//   busy is high only in the cycle where the cell row shifts and the
//   compare vector is captured, and a new request may be given while the
//   previous result is on the ports
// the receiver cannot stall; each result must be taken in its o_done cycle
// reset (i_rst_n low, synchronous) empties the list and drops any request in
//   flight; list contents are not cleared, only the length
// rejected requests (bad position, full list) leave the list unchanged
`default_nettype none

module positional_list_engine #(
    parameter int CAPACITY = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic [plist_pkg::MODE_W-1:0]           i_mode,
    input  wire logic [plist_pkg::POS_W-1:0]            i_position,
    input  wire logic signed [plist_pkg::VAL_W-1:0]     i_value,
    output logic                                        o_done,
    output logic [plist_pkg::STAT_W-1:0]                o_status,
    output logic signed [plist_pkg::VAL_W-1:0]          o_read_value,
    output logic [plist_pkg::POS_W-1:0]                 o_found_position,
    output logic [plist_pkg::POS_W-1:0]                 o_length
);
    import plist_pkg::*;

    t_dp_cmd cmd;

    plist_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    plist_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_mode           (i_mode),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_status         (o_status),
        .o_read_value     (o_read_value),
        .o_found_position (o_found_position),
        .o_length         (o_length)
    );

endmodule

`default_nettype wire

/* hdl/plist_chk.sv */
`default_nettype none

module plist_chk #(
    parameter int CAPACITY = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   start,
    input  wire logic                                   busy,
    input  wire logic                                   o_done,
    input  wire logic [plist_pkg::STAT_W-1:0]           o_status,
    input  wire logic signed [plist_pkg::VAL_W-1:0]     o_read_value,
    input  wire logic [plist_pkg::POS_W-1:0]            o_found_position,
    input  wire logic [plist_pkg::POS_W-1:0]            o_length
);
    import plist_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request not followed by busy");

    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_done)
        else $error("no result after busy cycle");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == ST_FULL |-> o_length == POS_W'(CAPACITY))
        else $error("full status with short list");

    a_notfound_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ST_OK |-> o_found_position == '0 && o_read_value == '0)
        else $error("payload set on failed request");

endmodule

bind positional_list_engine plist_chk #(
    .CAPACITY (CAPACITY)
) u_plist_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_done           (o_done),
    .o_status         (o_status),
    .o_read_value     (o_read_value),
    .o_found_position (o_found_position),
    .o_length         (o_length)
);

`default_nettype wire
